FILE: design/rea_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reprojection error accumulator package
// Shared constants, state and operation codes, and the request and response
// structs of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package rea_pkg;

    localparam int DEF_MAX_POINTS  = 4096;
    localparam int DEF_COORD_WIDTH = 32;

    localparam int TABLE_DEPTH = 24;
    localparam int COEF_W      = 32;
    localparam int FIELD_W     = 32;
    localparam int SUM_W       = 46;
    localparam int CNT_OUT_W   = 13;
    localparam int H_W         = 51;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 66;
    localparam int DIV_REM_W   = 51;
    localparam int DIV_BITS_W  = 46;
    localparam int STEP_W      = 6;
    localparam int SQRT_W      = 64;
    localparam int ROOT_W      = 32;
    localparam int IN_TDATA_W  = 264;
    localparam int OUT_TDATA_W = 160;

    localparam logic [STEP_W-1:0] DEPTH_DIV_STEPS = 6'd33;
    localparam logic [STEP_W-1:0] MEAN_DIV_STEPS  = 6'd46;
    localparam logic [STEP_W-1:0] SQRT_STEPS      = 6'd32;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic                         start;
        alu_op_t                      op;
        logic signed [MUL_W-1:0]      mul_a;
        logic signed [MUL_W-1:0]      mul_b;
        logic [DIV_REM_W-1:0]         div_rem;
        logic [DIV_BITS_W-1:0]        div_bits;
        logic [DIV_REM_W-1:0]         divisor;
        logic [STEP_W-1:0]            div_steps;
        logic [SQRT_W-1:0]            sqrt_in;
    } alu_req_t;

    typedef struct packed {
        logic                         done;
        logic signed [PROD_W-1:0]     prod;
        logic [DIV_BITS_W-1:0]        quo;
        logic [ROOT_W-1:0]            root;
    } alu_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_DEPTH,
        S_DCHK,
        S_DIV,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_SUM,
        S_ROOT,
        S_VIEWEND,
        S_ACCUM,
        S_MEAN_A,
        S_MEAN_AW,
        S_MEAN_I,
        S_MEAN_IW,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

FILE: design/reprojection_error_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Two-view reprojection error accumulator
// Projects each landmark through two stored projection matrices, measures
// the pixel error in both views and keeps running sums for the mean errors.
// ----------------------------------------------------------------------------
// The slave channel takes two kinds of item, chosen by s_tuser: a load item
// writes one of the 24 projection coefficients and finishes at once, and a
// point item carries a landmark, its two measured pixels and an inlier mark,
// with s_tlast closing the set. Each point item gives one result item on the
// master channel; m_tlast marks the item that closes the set and carries the
// mean errors, after which the sums and counts are cleared.
// The work runs on the single shared unit: up to twenty-two multiplies,
// four 33-step divisions and two 32-step square roots a point, and up to
// two 46-step divisions for the means. s_tready is high only while the
// block is idle.
// A finished result waits in the output register while the next item is
// accepted; when the receiver stalls, a second result waits in the block.
// Reset clears the sums, the counts and the handshake state; the coefficient
// table holds nothing defined until it is loaded.
// ----------------------------------------------------------------------------
module reprojection_error_accumulator #(
    parameter int MAX_POINTS  = rea_pkg::DEF_MAX_POINTS,
    parameter int COORD_WIDTH = rea_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // coef_index, coef_value, landmark_x, landmark_y, landmark_z,
    // meas_prev_x, meas_prev_y, meas_curr_x, meas_curr_y, is_inlier
    input  wire logic [rea_pkg::IN_TDATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // error_prev, error_curr, mean_error, inlier_mean_error, inlier_total,
    // point_total
    output logic [rea_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // no_inliers, zero_depth
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);
    import rea_pkg::*;

    localparam int COORD_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int CSH        = 32 - COORD_BITS;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W     = $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
    localparam logic [SUM_W:0]   SUM_MAX = {1'b0, {SUM_W{1'b1}}};

    function automatic logic signed [FIELD_W-1:0] sext_c(input logic [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] t;
        t = $signed(v << CSH);
        return t >>> CSH;
    endfunction

    state_t state_reg, state_next;
    logic                     view_reg, view_next;
    logic [1:0]               row_reg, row_next;
    logic [1:0]               k_reg, k_next;
    logic                     coord_reg, coord_next;
    logic signed [H_W-1:0]    acc_reg, acc_next;
    logic signed [H_W-1:0]    h0_reg, h0_next;
    logic signed [H_W-1:0]    h1_reg, h1_next;
    logic signed [H_W-1:0]    h2_reg, h2_next;
    logic [33:0]              m_reg, m_next;
    logic [35:0]              ax_reg, ax_next;
    logic [35:0]              ay_reg, ay_next;
    logic [63:0]              sx_reg, sx_next;
    logic [31:0]              e0_reg, e0_next;
    logic [31:0]              e1_reg, e1_next;
    logic signed [FIELD_W-1:0] pt0_reg, pt1_reg, pt2_reg;
    logic signed [FIELD_W-1:0] mpx_reg, mpy_reg, mcx_reg, mcy_reg;
    logic                     inl_reg, last_reg;
    logic                     zd_reg, zd_next;
    logic [SUM_W-1:0]         sall_reg, sall_next;
    logic [SUM_W-1:0]         sin_reg, sin_next;
    logic [CNT_W-1:0]         pcnt_reg, pcnt_next;
    logic [CNT_W-1:0]         icnt_reg, icnt_next;
    logic [31:0]              mall_reg, mall_next;
    logic [31:0]              min_reg, min_next;
    logic                     none_reg, none_next;
    logic                     ovalid_reg, ovalid_next;
    logic [OUT_TDATA_W-1:0]   odata_reg, odata_next;
    logic [1:0]               ouser_reg, ouser_next;
    logic                     olast_reg, olast_next;

    logic                     in_acc;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [COEF_W-1:0]        ram_rdata;
    alu_req_t                 req;
    alu_rsp_t                 rsp;

    logic signed [H_W-1:0]    num, an_s, ad_s;
    logic [H_W-1:0]           an, ad;
    logic                     neg;
    logic signed [35:0]       qs, es, meas;
    logic [35:0]              eabs;
    logic signed [FIELD_W-1:0] pt_sel;
    logic [64:0]              ssum;
    logic [SUM_W:0]           t_all, t_in;
    logic [31:0]              err_val;
    logic                     err_wr;

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign ram_we    = in_acc && (s_tuser == CMD_LOAD) && (s_tdata[4:0] < 5'(TABLE_DEPTH));
    assign ram_raddr = ADDR_W'((view_reg ? 5'd12 : 5'd0) + {1'b0, row_reg, 2'b00}
                       + {3'b000, k_reg});

    rea_ram #(
        .WIDTH (COEF_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s_tdata[ADDR_W-1:0]),
        .wdata (s_tdata[36:5]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rea_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        num  = coord_reg ? h1_reg : h0_reg;
        an_s = num[H_W-1] ? -num : num;
        ad_s = h2_reg[H_W-1] ? -h2_reg : h2_reg;
        an   = an_s;
        ad   = ad_s;
        neg  = num[H_W-1] ^ h2_reg[H_W-1];
        qs   = neg ? -$signed({2'b00, m_reg}) : $signed({2'b00, m_reg});
        case ({view_reg, coord_reg})
            2'b00:   meas = 36'(mpx_reg);
            2'b01:   meas = 36'(mpy_reg);
            2'b10:   meas = 36'(mcx_reg);
            default: meas = 36'(mcy_reg);
        endcase
        es   = qs - meas;
        eabs = es[35] ? 36'(-es) : 36'(es);
        case (k_reg)
            2'd0:    pt_sel = pt0_reg;
            2'd1:    pt_sel = pt1_reg;
            default: pt_sel = pt2_reg;
        endcase
        ssum  = {1'b0, sx_reg} + {1'b0, rsp.prod[63:0]};
        t_all = (SUM_W+1)'(sall_reg) + (SUM_W+1)'(e0_reg) + (SUM_W+1)'(e1_reg);
        t_in  = (SUM_W+1)'(sin_reg) + (SUM_W+1)'(e0_reg) + (SUM_W+1)'(e1_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        view_next   = view_reg;
        row_next    = row_reg;
        k_next      = k_reg;
        coord_next  = coord_reg;
        acc_next    = acc_reg;
        h0_next     = h0_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        m_next      = m_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        sx_next     = sx_reg;
        e0_next     = e0_reg;
        e1_next     = e1_reg;
        zd_next     = zd_reg;
        sall_next   = sall_reg;
        sin_next    = sin_reg;
        pcnt_next   = pcnt_reg;
        icnt_next   = icnt_reg;
        mall_next   = mall_reg;
        min_next    = min_reg;
        none_next   = none_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        olast_next  = olast_reg;
        err_val     = '0;
        err_wr      = 1'b0;
        req         = '0;
        req.op      = ALU_MUL;

        if (m_tvalid && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (s_tuser == CMD_POINT))
                begin
                    view_next  = 1'b0;
                    row_next   = '0;
                    k_next     = '0;
                    acc_next   = '0;
                    zd_next    = 1'b0;
                    none_next  = 1'b0;
                    mall_next  = '0;
                    min_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (k_reg == 2'd3)
                begin
                    acc_next = acc_reg + H_W'($signed(ram_rdata));
                    k_next   = '0;
                    case (row_reg)
                        2'd0:    h0_next = acc_next;
                        2'd1:    h1_next = acc_next;
                        default: h2_next = acc_next;
                    endcase
                    if (row_reg == 2'd2)
                    begin
                        state_next = S_DEPTH;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        acc_next   = '0;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    req.start  = 1'b1;
                    req.op     = ALU_MUL;
                    req.mul_a  = MUL_W'($signed(ram_rdata));
                    req.mul_b  = MUL_W'(pt_sel);
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (rsp.done)
                begin
                    acc_next   = acc_reg + H_W'(rsp.prod >>> 16);
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_DEPTH:
            begin
                if (h2_reg == '0)
                begin
                    zd_next    = 1'b1;
                    err_wr     = 1'b1;
                    err_val    = '0;
                    state_next = S_VIEWEND;
                end
                else
                begin
                    coord_next = 1'b0;
                    state_next = S_DCHK;
                end
            end
            S_DCHK:
            begin
                if ({17'b0, an} >= {ad, 17'b0})
                begin
                    m_next     = {1'b1, 33'b0};
                    state_next = S_DIFF;
                end
                else
                begin
                    req.start     = 1'b1;
                    req.op        = ALU_DIV;
                    req.div_rem   = DIV_REM_W'(an >> 17);
                    req.div_bits  = {an[16:0], 29'b0};
                    req.divisor   = ad;
                    req.div_steps = DEPTH_DIV_STEPS;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rsp.done)
                begin
                    m_next     = {1'b0, rsp.quo[32:0]};
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                if (coord_reg)
                begin
                    ay_next    = eabs;
                    state_next = S_SQX;
                end
                else
                begin
                    ax_next    = eabs;
                    coord_next = 1'b1;
                    state_next = S_DCHK;
                end
            end
            S_SQX:
            begin
                if ((ax_reg[35:32] != '0) || (ay_reg[35:32] != '0))
                begin
                    err_wr     = 1'b1;
                    err_val    = '1;
                    state_next = S_VIEWEND;
                end
                else
                begin
                    req.start  = 1'b1;
                    req.op     = ALU_MUL;
                    req.mul_a  = {1'b0, ax_reg[31:0]};
                    req.mul_b  = {1'b0, ax_reg[31:0]};
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (rsp.done)
                begin
                    sx_next    = rsp.prod[63:0];
                    req.start  = 1'b1;
                    req.op     = ALU_MUL;
                    req.mul_a  = {1'b0, ay_reg[31:0]};
                    req.mul_b  = {1'b0, ay_reg[31:0]};
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (rsp.done)
                begin
                    if (ssum[64])
                    begin
                        err_wr     = 1'b1;
                        err_val    = '1;
                        state_next = S_VIEWEND;
                    end
                    else
                    begin
                        req.start   = 1'b1;
                        req.op      = ALU_SQRT;
                        req.sqrt_in = ssum[63:0];
                        state_next  = S_ROOT;
                    end
                end
            end
            S_ROOT:
            begin
                if (rsp.done)
                begin
                    err_wr     = 1'b1;
                    err_val    = rsp.root;
                    state_next = S_VIEWEND;
                end
            end
            S_VIEWEND:
            begin
                if (view_reg)
                begin
                    state_next = S_ACCUM;
                end
                else
                begin
                    view_next  = 1'b1;
                    row_next   = '0;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = S_RD;
                end
            end
            S_ACCUM:
            begin
                if (pcnt_reg < CNT_MAX)
                begin
                    pcnt_next = pcnt_reg + 1'b1;
                    sall_next = (t_all > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : t_all[SUM_W-1:0];
                    if (inl_reg)
                    begin
                        icnt_next = icnt_reg + 1'b1;
                        sin_next  = (t_in > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : t_in[SUM_W-1:0];
                    end
                end
                state_next = last_reg ? S_MEAN_A : S_OUT;
            end
            S_MEAN_A:
            begin
                req.start     = 1'b1;
                req.op        = ALU_DIV;
                req.div_rem   = '0;
                req.div_bits  = sall_reg;
                req.divisor   = DIV_REM_W'({pcnt_reg, 1'b0});
                req.div_steps = MEAN_DIV_STEPS;
                state_next    = S_MEAN_AW;
            end
            S_MEAN_AW:
            begin
                if (rsp.done)
                begin
                    mall_next  = (rsp.quo[45:32] != '0) ? '1 : rsp.quo[31:0];
                    state_next = S_MEAN_I;
                end
            end
            S_MEAN_I:
            begin
                if (icnt_reg == '0)
                begin
                    none_next  = 1'b1;
                    min_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    req.start     = 1'b1;
                    req.op        = ALU_DIV;
                    req.div_rem   = '0;
                    req.div_bits  = sin_reg;
                    req.divisor   = DIV_REM_W'({icnt_reg, 1'b0});
                    req.div_steps = MEAN_DIV_STEPS;
                    state_next    = S_MEAN_IW;
                end
            end
            S_MEAN_IW:
            begin
                if (rsp.done)
                begin
                    min_next   = (rsp.quo[45:32] != '0) ? '1 : rsp.quo[31:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {6'b0, CNT_OUT_W'(pcnt_reg), CNT_OUT_W'(icnt_reg),
                                   min_reg, mall_reg, e1_reg, e0_reg};
                    ouser_next  = {zd_reg, none_reg};
                    olast_next  = last_reg;
                    if (last_reg)
                    begin
                        sall_next = '0;
                        sin_next  = '0;
                        pcnt_next = '0;
                        icnt_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (err_wr)
        begin
            if (view_reg)
            begin
                e1_next = err_val;
            end
            else
            begin
                e0_next = err_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sall_reg   <= '0;
            sin_reg    <= '0;
            pcnt_reg   <= '0;
            icnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sall_reg   <= sall_next;
            sin_reg    <= sin_next;
            pcnt_reg   <= pcnt_next;
            icnt_reg   <= icnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        view_reg  <= view_next;
        row_reg   <= row_next;
        k_reg     <= k_next;
        coord_reg <= coord_next;
        acc_reg   <= acc_next;
        h0_reg    <= h0_next;
        h1_reg    <= h1_next;
        h2_reg    <= h2_next;
        m_reg     <= m_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        sx_reg    <= sx_next;
        e0_reg    <= e0_next;
        e1_reg    <= e1_next;
        zd_reg    <= zd_next;
        mall_reg  <= mall_next;
        min_reg   <= min_next;
        none_reg  <= none_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
        olast_reg <= olast_next;
        if (in_acc && (s_tuser == CMD_POINT))
        begin
            pt0_reg  <= sext_c(s_tdata[68:37]);
            pt1_reg  <= sext_c(s_tdata[100:69]);
            pt2_reg  <= sext_c(s_tdata[132:101]);
            mpx_reg  <= sext_c(s_tdata[164:133]);
            mpy_reg  <= sext_c(s_tdata[196:165]);
            mcx_reg  <= sext_c(s_tdata[228:197]);
            mcy_reg  <= sext_c(s_tdata[260:229]);
            inl_reg  <= s_tdata[261];
            last_reg <= s_tlast;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

FILE: design/rea_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: design/rea_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// A registered multiplier, a restoring divider that takes one quotient bit a
// cycle, and a square root that takes one result bit a cycle.
// ----------------------------------------------------------------------------
module rea_alu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rea_pkg::alu_req_t req,
    output rea_pkg::alu_rsp_t      rsp
);
    import rea_pkg::*;

    alu_op_t                  op_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        cnt_reg;
    logic [DIV_REM_W-1:0]     rem_reg;
    logic [DIV_BITS_W-1:0]    bits_reg;
    logic [DIV_REM_W-1:0]     dvs_reg;
    logic [DIV_BITS_W-1:0]    quo_reg;
    logic [SQRT_W-1:0]        v_reg;
    logic [SQRT_W-1:0]        res_reg;
    logic [SQRT_W-1:0]        bit_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [DIV_REM_W:0] trial;
    logic [DIV_REM_W:0] diff;
    logic               ge;
    logic [SQRT_W-1:0]  sq_t;
    logic               sq_ge;

    always_comb
    begin
        trial = {rem_reg, bits_reg[DIV_BITS_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
        sq_t  = res_reg + bit_reg;
        sq_ge = v_reg >= sq_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= ALU_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg   <= req.op;
                busy_reg <= (req.op != ALU_MUL);
                done_reg <= (req.op == ALU_MUL);
                cnt_reg  <= (req.op == ALU_SQRT) ? SQRT_STEPS : req.div_steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            case (req.op)
                ALU_MUL:
                begin
                    prod_reg <= req.mul_a * req.mul_b;
                end
                ALU_DIV:
                begin
                    rem_reg  <= req.div_rem;
                    bits_reg <= req.div_bits;
                    dvs_reg  <= req.divisor;
                    quo_reg  <= '0;
                end
                ALU_SQRT:
                begin
                    v_reg   <= req.sqrt_in;
                    res_reg <= '0;
                    bit_reg <= {2'b01, {(SQRT_W-2){1'b0}}};
                end
                default:
                begin
                    prod_reg <= prod_reg;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                ALU_DIV:
                begin
                    rem_reg  <= ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
                    quo_reg  <= {quo_reg[DIV_BITS_W-2:0], ge};
                    bits_reg <= bits_reg << 1;
                end
                ALU_SQRT:
                begin
                    if (sq_ge)
                    begin
                        v_reg   <= v_reg - sq_t;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                default:
                begin
                    prod_reg <= prod_reg;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.root = res_reg[ROOT_W-1:0];

endmodule
`default_nettype wire
